>>> rtl/relative_strength_index_top_defines.svh
// Assertion macros shared by the RSI checker.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef RELATIVE_STRENGTH_INDEX_TOP_DEFINES_SVH
`define RELATIVE_STRENGTH_INDEX_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rsi_pkg.sv
// Package for the relative strength index block: widths, codes and the
// command and status structs between controller and datapath. No dependencies.
package rsi_pkg;

    localparam int PRICE_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int PERIOD_W    = 11;
    // Averages wrap modulo 2^ACC_W, like the arithmetic they follow.
    localparam int ACC_W       = 64;
    localparam int HFX_W       = 7 + FRAC_BITS;
    localparam int PROD_W      = ACC_W + HFX_W;
    localparam int STEP_W      = $clog2(PROD_W + 1);
    localparam int MUL_A_W     = ACC_W / 2;
    localparam int MUL_P_W     = MUL_A_W + HFX_W;

    localparam logic [HFX_W-1:0]    HUNDRED_FX   = HFX_W'(100) << FRAC_BITS;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = PERIOD_W'(1024);
    localparam logic [PERIOD_W-1:0] COUNT_MAX    = {PERIOD_W{1'b1}};

    // Arithmetic modes of the shared multiply and divide sequence.
    localparam logic [1:0] MODE_WARM   = 2'd0;
    localparam logic [1:0] MODE_SMOOTH = 2'd1;
    localparam logic [1:0] MODE_RATIO  = 2'd2;

    // Sources for the pending result.
    localparam logic [1:0] RES_NONE = 2'd0;
    localparam logic [1:0] RES_FULL = 2'd1;
    localparam logic [1:0] RES_QUOT = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       eval;
        logic       sel_dn;
        logic [1:0] mode;
        logic       mul_lo;
        logic       mul_hi;
        logic       acc_hi;
        logic       div_start;
        logic       write_avg;
        logic       res_load;
        logic [1:0] res_sel;
        logic       load_out;
    } rsi_cmd_t;

    typedef struct packed {
        logic first;
        logic idx_lt_p;
        logic idx_gt_p;
        logic dn_zero;
        logic den_zero;
        logic div_done;
    } rsi_sts_t;

endpackage

>>> rtl/relative_strength_index_top.sv
// Top level of the Wilder RSI block; instantiates rsi_ctrl and rsi_dp, uses rsi_pkg.
// The result is presented without a division during warm-up and on a series start; when
// warm-up ends and while smoothing it waits on the one-bit-per-cycle divider (two 64-step
// divisions by period plus one 87-step ratio, the last skipped when the down average is
// zero). Throughput: one transaction at a time; the next is taken as the result is
// registered. Reset: asynchronous, active low; clears the series state and sets period
// to 14.
module relative_strength_index_top
    import rsi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [PERIOD_W-1:0]    cfg_wdata,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [PRICE_WIDTH-1:0] price,
    input  logic                   series_start,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [HFX_W-1:0]       rsi_value,
    output logic                   valid_res
);

    // The controller walks each input transaction through a fixed sequence:
    // evaluate the price move, then, once the warm-up is over, divide or
    // smooth both averages and form the ratio 100*up/(up+down). Every step
    // is a command to the datapath; the datapath reports comparisons and
    // divider completion back as status.
    rsi_cmd_t cmd;
    rsi_sts_t sts;

    rsi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath holds the period register, the running averages, one
    // 32-bit by 23-bit multiplier used in halves, and the serial divider.
    // Its output register lets a finished result wait for the consumer
    // while the next input transaction is already accepted.
    rsi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .price        (price),
        .series_start (series_start),
        .cmd          (cmd),
        .sts          (sts),
        .rsi_value    (rsi_value),
        .valid_res    (valid_res)
    );

endmodule

>>> rtl/rsi_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on rsi_pkg.
module rsi_div
    import rsi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [STEP_W-1:0] steps,
    input  logic [ACC_W-1:0]  divisor,
    output logic              done,
    output logic [ACC_W-1:0]  quotient
);

    logic [ACC_W-1:0]  rem_reg;
    logic [ACC_W-1:0]  quo_reg;
    logic [ACC_W-1:0]  dsr_reg;
    logic [PROD_W-1:0] dvd_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic [ACC_W:0]    rem_sh;
    logic [ACC_W:0]    rem_sub;
    logic              ge;

    // The dividend is left aligned; its top bit enters the remainder each step.
    assign rem_sh  = {rem_reg, dvd_reg[PROD_W-1]};
    assign ge      = rem_sh >= {1'b0, dsr_reg};
    assign rem_sub = rem_sh - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            dsr_reg <= divisor;
            dvd_reg <= dividend;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg <= ge ? rem_sub[ACC_W-1:0] : rem_sh[ACC_W-1:0];
            quo_reg <= {quo_reg[ACC_W-2:0], ge};
            dvd_reg <= {dvd_reg[PROD_W-2:0], 1'b0};
        end
    end

    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = quo_reg;

endmodule

>>> rtl/rsi_dp.sv
// Datapath of the RSI block: series state, period register, shared multiplier,
// accumulator, divider and the output register. Depends on rsi_pkg and rsi_div.
module rsi_dp
    import rsi_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [PERIOD_W-1:0]    cfg_wdata,
    input  logic [PRICE_WIDTH-1:0] price,
    input  logic                   series_start,
    input  rsi_cmd_t               cmd,
    output rsi_sts_t               sts,
    output logic [HFX_W-1:0]       rsi_value,
    output logic                   valid_res
);

    logic [PERIOD_W-1:0]    period_reg;
    logic [PRICE_WIDTH-1:0] price_reg;
    logic                   start_reg;
    logic [PRICE_WIDTH-1:0] prev_price_reg;
    logic [ACC_W-1:0]       up_avg_reg;
    logic [ACC_W-1:0]       dn_avg_reg;
    logic [PERIOD_W-1:0]    count_reg;
    logic [PRICE_WIDTH-1:0] up_mv_reg;
    logic [PRICE_WIDTH-1:0] dn_mv_reg;
    logic [MUL_P_W-1:0]     mul_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic [HFX_W-1:0]       res_rsi_reg;
    logic                   res_vld_reg;
    logic [HFX_W-1:0]       out_rsi_reg;
    logic                   out_vld_reg;

    logic [PERIOD_W-1:0]    eff_p;
    logic [PRICE_WIDTH-1:0] move_up;
    logic [PRICE_WIDTH-1:0] move_dn;
    logic [ACC_W-1:0]       avg_sel;
    logic [PRICE_WIDTH-1:0] mv_sel;
    logic [ACC_W-1:0]       mv_shift;
    logic [MUL_A_W-1:0]     mul_a;
    logic [HFX_W-1:0]       mul_b;
    logic [MUL_P_W-1:0]     mul_prod;
    logic [ACC_W-1:0]       den;
    logic [PROD_W-1:0]      div_dividend;
    logic [STEP_W-1:0]      div_steps;
    logic [ACC_W-1:0]       div_divisor;
    logic                   div_done;
    logic [ACC_W-1:0]       quotient;

    // Out-of-range periods are clamped to the supported span.
    always_comb
    begin
        priority if (period_reg == '0)
        begin
            eff_p = PERIOD_W'(1);
        end
        else if (period_reg > PERIOD_MAX)
        begin
            eff_p = PERIOD_MAX;
        end
        else
        begin
            eff_p = period_reg;
        end
    end

    assign move_up  = (price_reg > prev_price_reg) ? price_reg - prev_price_reg : '0;
    assign move_dn  = (prev_price_reg > price_reg) ? prev_price_reg - price_reg : '0;
    assign avg_sel  = cmd.sel_dn ? dn_avg_reg : up_avg_reg;
    assign mv_sel   = cmd.sel_dn ? dn_mv_reg : up_mv_reg;
    assign mv_shift = ACC_W'({mv_sel, {FRAC_BITS{1'b0}}});
    assign den      = up_avg_reg + dn_avg_reg;

    assign mul_a    = cmd.mul_hi ? avg_sel[ACC_W-1:MUL_A_W] : avg_sel[MUL_A_W-1:0];
    assign mul_b    = (cmd.mode == MODE_RATIO) ? HUNDRED_FX
                                               : HFX_W'(eff_p - PERIOD_W'(1));
    assign mul_prod = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    always_comb
    begin
        unique case (cmd.mode)
            MODE_WARM:
            begin
                div_dividend = {avg_sel[ACC_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}},
                                {HFX_W{1'b0}}};
                div_steps    = STEP_W'(ACC_W);
                div_divisor  = ACC_W'(eff_p);
            end
            MODE_SMOOTH:
            begin
                div_dividend = {acc_reg[ACC_W-1:0], {HFX_W{1'b0}}};
                div_steps    = STEP_W'(ACC_W);
                div_divisor  = ACC_W'(eff_p);
            end
            default:
            begin
                div_dividend = acc_reg;
                div_steps    = STEP_W'(PROD_W);
                div_divisor  = den;
            end
        endcase
    end

    rsi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .steps    (div_steps),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Series state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RESET;
            prev_price_reg <= '0;
            up_avg_reg     <= '0;
            dn_avg_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                period_reg <= cfg_wdata;
            end
            if (cmd.eval)
            begin
                prev_price_reg <= price_reg;
                if (sts.first)
                begin
                    up_avg_reg <= '0;
                    dn_avg_reg <= '0;
                    count_reg  <= PERIOD_W'(1);
                end
                else
                begin
                    if (!sts.idx_gt_p)
                    begin
                        up_avg_reg <= up_avg_reg + ACC_W'(move_up);
                        dn_avg_reg <= dn_avg_reg + ACC_W'(move_dn);
                    end
                    if (count_reg != COUNT_MAX)
                    begin
                        count_reg <= count_reg + PERIOD_W'(1);
                    end
                end
            end
            else if (cmd.write_avg)
            begin
                if (cmd.sel_dn)
                begin
                    dn_avg_reg <= quotient;
                end
                else
                begin
                    up_avg_reg <= quotient;
                end
            end
        end
    end

    // Working registers and the result path.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            price_reg <= price;
            start_reg <= series_start;
        end
        if (cmd.eval)
        begin
            up_mv_reg <= move_up;
            dn_mv_reg <= move_dn;
        end
        if (cmd.mul_lo || cmd.mul_hi)
        begin
            mul_reg <= mul_prod;
        end
        if (cmd.mul_hi)
        begin
            acc_reg <= PROD_W'(mul_reg)
                     + ((cmd.mode == MODE_RATIO) ? '0 : PROD_W'(mv_shift));
        end
        else if (cmd.acc_hi)
        begin
            acc_reg <= acc_reg + (PROD_W'(mul_reg) << MUL_A_W);
        end
        if (cmd.res_load)
        begin
            unique case (cmd.res_sel)
                RES_NONE:
                begin
                    res_rsi_reg <= '0;
                    res_vld_reg <= 1'b0;
                end
                RES_FULL:
                begin
                    res_rsi_reg <= HUNDRED_FX;
                    res_vld_reg <= 1'b1;
                end
                RES_QUOT:
                begin
                    res_rsi_reg <= quotient[HFX_W-1:0];
                    res_vld_reg <= 1'b1;
                end
                default:
                begin
                    res_rsi_reg <= '0;
                    res_vld_reg <= 1'b0;
                end
            endcase
        end
        if (cmd.load_out)
        begin
            out_rsi_reg <= res_rsi_reg;
            out_vld_reg <= res_vld_reg;
        end
    end

    assign sts.first    = start_reg || (count_reg == '0);
    assign sts.idx_lt_p = count_reg < eff_p;
    assign sts.idx_gt_p = count_reg > eff_p;
    assign sts.dn_zero  = dn_avg_reg == '0;
    assign sts.den_zero = den == '0;
    assign sts.div_done = div_done;

    assign rsi_value = out_rsi_reg;
    assign valid_res = out_vld_reg;

endmodule

>>> rtl/rsi_ctrl.sv
// Controller of the RSI block: sequences each transaction through the datapath
// and owns both handshakes. Depends on rsi_pkg.
module rsi_ctrl
    import rsi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  rsi_sts_t sts,
    output rsi_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_EVAL     = 4'd1;
    localparam logic [3:0] ST_MUL_A    = 4'd2;
    localparam logic [3:0] ST_MUL_B    = 4'd3;
    localparam logic [3:0] ST_MUL_C    = 4'd4;
    localparam logic [3:0] ST_DIV_LOAD = 4'd5;
    localparam logic [3:0] ST_DIV_RUN  = 4'd6;
    localparam logic [3:0] ST_WRITE    = 4'd7;
    localparam logic [3:0] ST_RATIO    = 4'd8;
    localparam logic [3:0] ST_OUT      = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] mode_reg;
    logic [1:0] mode_next;
    logic       sel_reg;
    logic       sel_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        cmd        = '0;
        cmd.mode   = mode_reg;
        cmd.sel_dn = sel_reg;
        state_next = state_reg;
        mode_next  = mode_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                sel_next = 1'b0;
                if (sts.first || sts.idx_lt_p)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_NONE;
                    state_next   = ST_OUT;
                end
                else if (sts.idx_gt_p)
                begin
                    mode_next  = MODE_SMOOTH;
                    state_next = ST_MUL_A;
                end
                else
                begin
                    mode_next  = MODE_WARM;
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_MUL_A:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                cmd.acc_hi = 1'b1;
                state_next = ST_DIV_LOAD;
            end
            ST_DIV_LOAD:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (mode_reg == MODE_RATIO)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_QUOT;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.write_avg = 1'b1;
                    if (!sel_reg)
                    begin
                        sel_next   = 1'b1;
                        state_next = (mode_reg == MODE_WARM) ? ST_DIV_LOAD : ST_MUL_A;
                    end
                    else
                    begin
                        state_next = ST_RATIO;
                    end
                end
            end
            ST_RATIO:
            begin
                if (sts.dn_zero || sts.den_zero)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_FULL;
                    state_next   = ST_OUT;
                end
                else
                begin
                    mode_next  = MODE_RATIO;
                    sel_next   = 1'b0;
                    state_next = ST_MUL_A;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_WARM;
            sel_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/rsi_chk.sv
// Port-level checker for the RSI block and its bind to the top level.
// Depends on rsi_pkg and relative_strength_index_top_defines.svh.
`include "relative_strength_index_top_defines.svh"

module rsi_chk
    import rsi_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [HFX_W-1:0] rsi_value,
    input logic             valid_res
);

    // The index never exceeds one hundred.
    `RSI_ASSERT_SAME(a_rsi_range, out_valid, rsi_value <= HUNDRED_FX, "RSI above 100")

    // A warm-up result carries a zero value.
    `RSI_ASSERT_SAME(a_warm_zero, out_valid && !valid_res, rsi_value == '0,
                     "nonzero RSI during warm-up")

    // One transaction is worked on at a time.
    `RSI_ASSERT_NEXT(a_one_inflight, in_valid && in_ready, !in_ready,
                     "input taken while busy")

    // A stalled result holds.
    `RSI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                     out_valid && $stable(rsi_value) && $stable(valid_res),
                     "stalled result changed")

endmodule

bind relative_strength_index_top rsi_chk u_rsi_chk (.*);
